// ----- rtl/core/gwwb_pkg.sv -----
// ----------------------------------------------------------------------------
// gwwb_pkg: shared definitions for the gray-world white balance unit
// Widths, fixed-point constants, channel and command codes, and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gwwb_pkg;

    localparam int PIX_W  = 8;                 // one color channel
    localparam int SUM_W  = 28;                // running channel sum
    localparam int GAIN_W = 24;                // Q8.16 gain
    localparam int FRAC_W = 16;                // gain fraction bits
    localparam int TOT_W  = SUM_W + 2;         // sum of three channel sums
    localparam int NUM_W  = TOT_W + FRAC_W + 2; // 2*T*2^16 + 3*S
    localparam int DEN_W  = SUM_W + 3;         // 6*S
    localparam int STEP_W = $clog2(GAIN_W);    // divider step counter

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;
    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    // input command codes
    localparam logic CMD_ACC   = 1'b0;
    localparam logic CMD_APPLY = 1'b1;

    typedef logic [1:0] chan_t;
    localparam chan_t CH_RED   = 2'd0;
    localparam chan_t CH_GREEN = 2'd1;
    localparam chan_t CH_BLUE  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic  acc_en;        // add input pixel to the sums
        logic  acc_clear;     // start sums from zero
        logic  out_load_in;   // scale input pixel into output register
        logic  pix_hold;      // capture input pixel for later
        logic  total_load;    // register the sum of all three sums
        logic  div_load;      // set up numerator/denominator for channel
        logic  div_check;     // resolve zero/saturation or seed divider
        logic  div_step;      // one restoring division step
        logic  gain_write;    // store quotient as channel gain
        logic  out_load_held; // scale held pixel into output register
        chan_t ch;            // channel under division
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic den_zero;       // channel sum is zero
        logic gain_ovf;       // quotient would exceed GAIN_MAX
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/gwwb_dp.sv -----
// ----------------------------------------------------------------------------
// gwwb_dp: white balance datapath
// Channel sums, iterative gain divider, gain registers, pixel scaling and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gwwb_dp
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gwwb_pkg::dp_cmd_t          ctl,
    output gwwb_pkg::dp_stat_t              stat,
    input  wire logic [gwwb_pkg::PIX_W-1:0] red_in,
    input  wire logic [gwwb_pkg::PIX_W-1:0] green_in,
    input  wire logic [gwwb_pkg::PIX_W-1:0] blue_in,
    output logic      [gwwb_pkg::PIX_W-1:0] red_out,
    output logic      [gwwb_pkg::PIX_W-1:0] green_out,
    output logic      [gwwb_pkg::PIX_W-1:0] blue_out
);

    localparam int PROD_W = gwwb_pkg::PIX_W + gwwb_pkg::GAIN_W + 1;

    function automatic logic [gwwb_pkg::SUM_W-1:0] sat_add(
        input logic [gwwb_pkg::SUM_W-1:0] base,
        input logic [gwwb_pkg::PIX_W-1:0] v
    );
        logic [gwwb_pkg::SUM_W:0] s;
        s = (gwwb_pkg::SUM_W + 1)'(base) + (gwwb_pkg::SUM_W + 1)'(v);
        return s[gwwb_pkg::SUM_W] ? gwwb_pkg::SUM_MAX : s[gwwb_pkg::SUM_W-1:0];
    endfunction

    // round to nearest (ties up), clamp to 255
    function automatic logic [gwwb_pkg::PIX_W-1:0] scale(
        input logic [gwwb_pkg::PIX_W-1:0]  v,
        input logic [gwwb_pkg::GAIN_W-1:0] gain
    );
        logic [PROD_W-1:0] p;
        p = PROD_W'(v) * PROD_W'(gain) + (PROD_W'(1) << (gwwb_pkg::FRAC_W - 1));
        if (p[PROD_W-1:gwwb_pkg::FRAC_W+gwwb_pkg::PIX_W] != '0)
            return {gwwb_pkg::PIX_W{1'b1}};
        return p[gwwb_pkg::FRAC_W+gwwb_pkg::PIX_W-1:gwwb_pkg::FRAC_W];
    endfunction

    logic [gwwb_pkg::SUM_W-1:0]  red_sum_reg, green_sum_reg, blue_sum_reg;
    logic [gwwb_pkg::GAIN_W-1:0] red_gain_reg, green_gain_reg, blue_gain_reg;
    logic [gwwb_pkg::PIX_W-1:0]  hold_r_reg, hold_g_reg, hold_b_reg;
    logic [gwwb_pkg::TOT_W-1:0]  total_reg;
    logic [gwwb_pkg::NUM_W-1:0]  num_reg;
    logic [gwwb_pkg::DEN_W-1:0]  den_reg;
    logic [gwwb_pkg::DEN_W-1:0]  rem_reg;
    logic [gwwb_pkg::GAIN_W-1:0] low_reg;
    logic [gwwb_pkg::GAIN_W-1:0] quo_reg;
    logic [gwwb_pkg::PIX_W-1:0]  red_out_reg, green_out_reg, blue_out_reg;

    logic [gwwb_pkg::SUM_W-1:0]  sel_sum;
    logic [gwwb_pkg::GAIN_W-1:0] num_hi;
    logic [gwwb_pkg::DEN_W:0]    shifted;
    logic [gwwb_pkg::DEN_W:0]    diff;
    logic                        ge;
    logic [gwwb_pkg::PIX_W-1:0]  src_r, src_g, src_b;

    always_comb
    begin
        case (ctl.ch)
            gwwb_pkg::CH_RED:   sel_sum = red_sum_reg;
            gwwb_pkg::CH_GREEN: sel_sum = green_sum_reg;
            gwwb_pkg::CH_BLUE:  sel_sum = blue_sum_reg;
            default:            sel_sum = '0;
        endcase
    end

    // num >= den * 2^24 exactly when num[47:24] >= den
    assign num_hi        = num_reg[gwwb_pkg::NUM_W-1:gwwb_pkg::GAIN_W];
    assign stat.den_zero = (den_reg == '0);
    assign stat.gain_ovf = (gwwb_pkg::DEN_W'(num_hi) >= den_reg);

    assign shifted = {rem_reg, low_reg[gwwb_pkg::GAIN_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    assign src_r = ctl.out_load_held ? hold_r_reg : red_in;
    assign src_g = ctl.out_load_held ? hold_g_reg : green_in;
    assign src_b = ctl.out_load_held ? hold_b_reg : blue_in;

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_sum_reg    <= '0;
            green_sum_reg  <= '0;
            blue_sum_reg   <= '0;
            red_gain_reg   <= gwwb_pkg::GAIN_ONE;
            green_gain_reg <= gwwb_pkg::GAIN_ONE;
            blue_gain_reg  <= gwwb_pkg::GAIN_ONE;
        end
        else
        begin
            if (ctl.acc_en)
            begin
                red_sum_reg   <= sat_add(ctl.acc_clear ? '0 : red_sum_reg, red_in);
                green_sum_reg <= sat_add(ctl.acc_clear ? '0 : green_sum_reg, green_in);
                blue_sum_reg  <= sat_add(ctl.acc_clear ? '0 : blue_sum_reg, blue_in);
            end
            if (ctl.gain_write)
            begin
                case (ctl.ch)
                    gwwb_pkg::CH_RED:   red_gain_reg   <= quo_reg;
                    gwwb_pkg::CH_GREEN: green_gain_reg <= quo_reg;
                    gwwb_pkg::CH_BLUE:  blue_gain_reg  <= quo_reg;
                    default:            ;
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctl.pix_hold)
        begin
            hold_r_reg <= red_in;
            hold_g_reg <= green_in;
            hold_b_reg <= blue_in;
        end
        if (ctl.total_load)
            total_reg <= gwwb_pkg::TOT_W'(red_sum_reg) + gwwb_pkg::TOT_W'(green_sum_reg)
                       + gwwb_pkg::TOT_W'(blue_sum_reg);
        if (ctl.div_load)
        begin
            num_reg <= (gwwb_pkg::NUM_W'(total_reg) << (gwwb_pkg::FRAC_W + 1))
                     + (gwwb_pkg::NUM_W'(sel_sum) << 1) + gwwb_pkg::NUM_W'(sel_sum);
            den_reg <= (gwwb_pkg::DEN_W'(sel_sum) << 2) + (gwwb_pkg::DEN_W'(sel_sum) << 1);
        end
        if (ctl.div_check)
        begin
            rem_reg <= gwwb_pkg::DEN_W'(num_hi);
            low_reg <= num_reg[gwwb_pkg::GAIN_W-1:0];
            if (stat.den_zero)
                quo_reg <= '0;
            else if (stat.gain_ovf)
                quo_reg <= gwwb_pkg::GAIN_MAX;
            else
                quo_reg <= '0;
        end
        if (ctl.div_step)
        begin
            rem_reg <= ge ? diff[gwwb_pkg::DEN_W-1:0] : shifted[gwwb_pkg::DEN_W-1:0];
            low_reg <= low_reg << 1;
            quo_reg <= {quo_reg[gwwb_pkg::GAIN_W-2:0], ge};
        end
        if (ctl.out_load_in || ctl.out_load_held)
        begin
            red_out_reg   <= scale(src_r, red_gain_reg);
            green_out_reg <= scale(src_g, green_gain_reg);
            blue_out_reg  <= scale(src_b, blue_gain_reg);
        end
    end

    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;

    // restoring divider keeps the partial remainder below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_step |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_gain_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.div_check && stat.den_zero) |=> (quo_reg == '0))
        else $error("zero channel sum did not give zero gain");

    a_gain_write_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.div_check && !stat.den_zero && stat.gain_ovf)
        |=> (quo_reg == gwwb_pkg::GAIN_MAX))
        else $error("overflowing gain not saturated");

endmodule

`default_nettype wire

// ----- rtl/core/gwwb_ctrl.sv -----
// ----------------------------------------------------------------------------
// gwwb_ctrl: white balance controller
// Handshakes, output valid, and the sequence of the per-frame gain division.
// ----------------------------------------------------------------------------
`default_nettype none

module gwwb_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               cmd,
    input  wire logic               first_of_pass,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output gwwb_pkg::dp_cmd_t       ctl,
    input  wire gwwb_pkg::dp_stat_t stat
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_TOTAL = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_CHECK = 7'b0001000,
        ST_STEP  = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    localparam logic [gwwb_pkg::STEP_W-1:0] STEP_LAST = gwwb_pkg::STEP_W'(gwwb_pkg::GAIN_W - 1);

    state_t                        state_reg, state_next;
    gwwb_pkg::chan_t               ch_reg, ch_next;
    logic [gwwb_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          in_xfer;
    logic                          out_xfer;
    logic                          out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        ctl            = '0;
        ctl.ch         = ch_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (cmd == gwwb_pkg::CMD_ACC)
                    begin
                        ctl.acc_en    = 1'b1;
                        ctl.acc_clear = first_of_pass;
                    end
                    else if (first_of_pass)
                    begin
                        ctl.pix_hold = 1'b1;
                        state_next   = ST_TOTAL;
                    end
                    else
                    begin
                        ctl.out_load_in = 1'b1;
                        out_valid_next  = 1'b1;
                    end
                end
            end
            ST_TOTAL:
            begin
                ctl.total_load = 1'b1;
                ch_next        = gwwb_pkg::CH_RED;
                state_next     = ST_LOAD;
            end
            ST_LOAD:
            begin
                ctl.div_load = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                ctl.div_check = 1'b1;
                step_next     = '0;
                state_next    = (stat.den_zero || stat.gain_ovf) ? ST_WRITE : ST_STEP;
            end
            ST_STEP:
            begin
                ctl.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                ctl.gain_write = 1'b1;
                if (ch_reg == gwwb_pkg::CH_BLUE)
                    state_next = ST_EMIT;
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ctl.out_load_held = 1'b1;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= gwwb_pkg::CH_RED;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_first_apply_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && cmd == gwwb_pkg::CMD_APPLY && first_of_pass) |=> (state_reg == ST_TOTAL))
        else $error("first apply pixel did not start gain computation");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT
            || (in_xfer && cmd == gwwb_pkg::CMD_APPLY)))
        else $error("result raised without an apply pixel");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (ch_reg != 2'd3))
        else $error("division channel out of range");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (step_reg <= STEP_LAST))
        else $error("divider step count overran");

endmodule

`default_nettype wire

// ----- rtl/core/gray_world_white_balance_unit.sv -----
// ----------------------------------------------------------------------------
// gray_world_white_balance_unit: two-pass gray-world white balance
//
// Input channel (in_valid / in_stall): one RGB pixel per transfer, with cmd
// (0 accumulate pass, 1 apply pass) and first_of_pass. Output channel
// (out_valid / out_stall): one balanced RGB pixel per apply-pass transfer;
// accumulate-pass pixels produce nothing.
// Accumulate pixels are taken one per cycle while idle and the output is
// not stalled; first_of_pass clears the sums. Later apply pixels likewise
// are taken one per cycle and appear in the next cycle from the output
// register (one 8x24 multiply per channel, then round and clamp). The first
// apply pixel of a pass runs the gain division with in_stall high: the sums
// are totalled, then one shared restoring divider runs load, check, 24 steps
// (skipped for a zero or clipped gain) and write per channel, then emit.
// Reset clears the sums and sets all gains to 1.0 (Q8.16), so apply pixels
// before any gain computation pass through unchanged.
// When the receiver stalls a held result, in_stall rises too; the result
// holds in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gray_world_white_balance_unit
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input pixel channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       cmd,
    input  wire logic                       first_of_pass,
    input  wire logic [gwwb_pkg::PIX_W-1:0] red_in,
    input  wire logic [gwwb_pkg::PIX_W-1:0] green_in,
    input  wire logic [gwwb_pkg::PIX_W-1:0] blue_in,
    // output pixel channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [gwwb_pkg::PIX_W-1:0] red_out,
    output logic      [gwwb_pkg::PIX_W-1:0] green_out,
    output logic      [gwwb_pkg::PIX_W-1:0] blue_out
);

    gwwb_pkg::dp_cmd_t  ctl;   // controller commands
    gwwb_pkg::dp_stat_t stat;  // divider status back to controller

    // handshakes and division sequencing
    gwwb_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .first_of_pass (first_of_pass),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ctl           (ctl),
        .stat          (stat)
    );

    // sums, gains, divider and pixel scaling
    gwwb_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

`default_nettype wire

// ----- verif/gray_world_white_balance_unit_tb.sv -----
// ----------------------------------------------------------------------------
// gray_world_white_balance_unit_tb: self-checking bench for the white balance
// Drives accumulate and apply passes through the pixel channel. A behavioral
// model of the running sums and Q8.16 gains predicts the balanced pixels not
// pinned by hand, and a scoreboard checks the outputs field by field. Both
// channels idle and stall at random, and the receiver holds off once long
// enough to back the block up.
// ----------------------------------------------------------------------------

module gray_world_white_balance_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // Run sizing
    // ------------------------------------------------------------------------
    localparam int          RANDOM_ITEMS = 580;
    localparam int          HOLD_CYCLES  = 400;       // long receiver hold-off
    localparam int          DRAIN_CYCLES = 120;       // > one gain division
    localparam int          NUM_DIRECTED = 25;
    // Slowest correct run is well under 300 us; this leaves several times that.
    localparam longint      TIMEOUT_NS   = 64'd2_000_000;
    localparam int          ERR_PRINTS   = 20;

    typedef struct packed {
        logic [gwwb_pkg::PIX_W-1:0] r;
        logic [gwwb_pkg::PIX_W-1:0] g;
        logic [gwwb_pkg::PIX_W-1:0] b;
    } pix_t;

    // One directed row: a pixel, how many times to send it back to back,
    // and optionally a hand-computed result that replaces the prediction.
    typedef struct packed {
        logic        op;
        logic        first;
        pix_t        px;
        logic [20:0] reps;
        logic        pinned;
        pix_t        want;
    } stim_row_t;

    localparam pix_t ZERO_PX = '0;

    // ------------------------------------------------------------------------
    // Clock, reset, DUT signals
    // ------------------------------------------------------------------------
    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       in_valid      = 1'b0;
    logic                       in_stall;
    logic                       cmd           = gwwb_pkg::CMD_ACC;
    logic                       first_of_pass = 1'b0;
    logic [gwwb_pkg::PIX_W-1:0] red_in        = '0;
    logic [gwwb_pkg::PIX_W-1:0] green_in      = '0;
    logic [gwwb_pkg::PIX_W-1:0] blue_in       = '0;
    logic                       out_valid;
    logic                       out_stall     = 1'b0;
    logic [gwwb_pkg::PIX_W-1:0] red_out;
    logic [gwwb_pkg::PIX_W-1:0] green_out;
    logic [gwwb_pkg::PIX_W-1:0] blue_out;

    // Hand-computed result riding along with the pixel on the input channel
    logic             cur_pinned    = 1'b0;
    pix_t             cur_want      = '0;

    always #1 clk = ~clk;

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    gray_world_white_balance_unit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .first_of_pass (first_of_pass),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out)
    );

    // ------------------------------------------------------------------------
    // Gray-world model: running sums and current gains
    // ------------------------------------------------------------------------
    logic [gwwb_pkg::SUM_W-1:0]  acc_r = '0;
    logic [gwwb_pkg::SUM_W-1:0]  acc_g = '0;
    logic [gwwb_pkg::SUM_W-1:0]  acc_b = '0;
    logic [gwwb_pkg::GAIN_W-1:0] wb_r  = gwwb_pkg::GAIN_ONE;
    logic [gwwb_pkg::GAIN_W-1:0] wb_g  = gwwb_pkg::GAIN_ONE;
    logic [gwwb_pkg::GAIN_W-1:0] wb_b  = gwwb_pkg::GAIN_ONE;

    pix_t expected_pixels [$];

    int errors        = 0;
    int transfers_in  = 0;
    int results_seen  = 0;
    int gain_updates  = 0;
    int gains_clipped = 0;   // gains that hit GAIN_MAX
    int gains_zeroed  = 0;   // gains from an empty channel
    int in_backed_up  = 0;   // cycles the sender waited on in_stall

    // Sum clamps at the top of its range instead of wrapping.
    function automatic logic [gwwb_pkg::SUM_W-1:0] add_clamped(
        input logic [gwwb_pkg::SUM_W-1:0] s,
        input logic [gwwb_pkg::PIX_W-1:0] v
    );
        logic [gwwb_pkg::SUM_W:0] t;
        t = {1'b0, s} + (gwwb_pkg::SUM_W + 1)'(v);
        return (t > {1'b0, gwwb_pkg::SUM_MAX}) ? gwwb_pkg::SUM_MAX
                                               : t[gwwb_pkg::SUM_W-1:0];
    endfunction

    // (T/3)/S in Q8.16, round half up, clipped; empty channel gives zero.
    function automatic logic [gwwb_pkg::GAIN_W-1:0] gray_gain(
        input logic [gwwb_pkg::TOT_W-1:0] total,
        input logic [gwwb_pkg::SUM_W-1:0] chan_sum
    );
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        if (chan_sum == '0)
            return '0;
        num = (64'(total) << (gwwb_pkg::FRAC_W + 1)) + 64'(chan_sum) * 64'd3;
        den = 64'(chan_sum) * 64'd6;
        q   = num / den;
        return (q > 64'(gwwb_pkg::GAIN_MAX)) ? gwwb_pkg::GAIN_MAX
                                             : q[gwwb_pkg::GAIN_W-1:0];
    endfunction

    function automatic logic [gwwb_pkg::PIX_W-1:0] scale_channel(
        input logic [gwwb_pkg::PIX_W-1:0]  v,
        input logic [gwwb_pkg::GAIN_W-1:0] gain
    );
        logic [63:0] p;
        p = (64'(v) * 64'(gain) + (64'd1 << (gwwb_pkg::FRAC_W - 1))) >> gwwb_pkg::FRAC_W;
        return (p > 64'd255) ? '1 : p[gwwb_pkg::PIX_W-1:0];
    endfunction

    function automatic void note_gain(input logic [gwwb_pkg::GAIN_W-1:0] gain);
        if (gain == gwwb_pkg::GAIN_MAX)
            gains_clipped++;
        if (gain == '0)
            gains_zeroed++;
    endfunction

    // Advance the model by one accepted pixel; apply pixels produce a result.
    task automatic balance_pixel(input logic op, input logic first, input pix_t px,
                                 output bit produced, output pix_t result);
        logic [gwwb_pkg::TOT_W-1:0] total;
        produced = 1'b0;
        result   = '0;
        if (op == gwwb_pkg::CMD_ACC)
        begin
            if (first)
            begin
                acc_r = '0;
                acc_g = '0;
                acc_b = '0;
            end
            acc_r = add_clamped(acc_r, px.r);
            acc_g = add_clamped(acc_g, px.g);
            acc_b = add_clamped(acc_b, px.b);
        end
        else
        begin
            if (first)
            begin
                total = gwwb_pkg::TOT_W'(acc_r) + gwwb_pkg::TOT_W'(acc_g)
                      + gwwb_pkg::TOT_W'(acc_b);
                wb_r  = gray_gain(total, acc_r);
                wb_g  = gray_gain(total, acc_g);
                wb_b  = gray_gain(total, acc_b);
                note_gain(wb_r);
                note_gain(wb_g);
                note_gain(wb_b);
                gain_updates++;
            end
            result.r = scale_channel(px.r, wb_r);
            result.g = scale_channel(px.g, wb_g);
            result.b = scale_channel(px.b, wb_b);
            produced = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= ERR_PRINTS)
            $display("ERROR @%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard. Everything is sampled at the rising edge, before the
    // nonblocking updates of that edge land, so the handshake values seen
    // here are exactly the ones the DUT saw.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit   produced;
        pix_t predicted;
        pix_t want;
        if (rst_n)
        begin
            // output side first: a result never leaves on the edge its pixel enters
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_pixels.size() == 0)
                    report_mismatch("output transfer with nothing pending",
                                    int'(red_out), -1);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (red_out !== want.r)
                        report_mismatch("red_out", int'(red_out), int'(want.r));
                    if (green_out !== want.g)
                        report_mismatch("green_out", int'(green_out), int'(want.g));
                    if (blue_out !== want.b)
                        report_mismatch("blue_out", int'(blue_out), int'(want.b));
                end
            end
            if (in_valid && in_stall)
                in_backed_up++;
            if (in_valid && !in_stall)
            begin
                transfers_in++;
                balance_pixel(cmd, first_of_pass, {red_in, green_in, blue_in},
                              produced, predicted);
                if (produced)
                    expected_pixels.push_back(cur_pinned ? cur_want : predicted);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Idle pattern shared by both sides: mostly none or short, a few long.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, calm stretches, plus the long hold-off
    // ------------------------------------------------------------------------
    logic hold_off     = 1'b0;
    bit   random_phase = 1'b0;
    int   rx_stall_left;
    int   rx_run_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall     <= 1'b0;
            rx_stall_left <= 0;
            rx_run_left   <= 0;
        end
        else if (rx_stall_left != 0)
        begin
            out_stall     <= 1'b1;
            rx_stall_left <= rx_stall_left - 1;
        end
        else if (rx_run_left != 0)
        begin
            out_stall   <= hold_off;
            rx_run_left <= rx_run_left - 1;
        end
        else
        begin
            out_stall     <= hold_off;
            rx_stall_left <= pick_gap();
            rx_run_left   <= ($urandom_range(0, 15) == 0) ? $urandom_range(100, 200)
                                                          : $urandom_range(1, 12);
        end
    end

    // Long hold-off early in the random part: the output register fills,
    // in_stall rises, and the sender keeps its pixel offered meanwhile.
    initial
    begin
        wait (random_phase);
        repeat ($urandom_range(50, 200)) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    bit tx_calm = 1'b0;

    // Called at a rising edge; returns at the edge where the pixel transfers.
    task automatic send_pixel(input logic op, input logic first, input pix_t px,
                              input logic pinned, input pix_t want, input bit no_gap);
        int gap;
        gap = (no_gap || tx_calm) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        first_of_pass <= first;
        red_in        <= px.r;
        green_in      <= px.g;
        blue_in       <= px.b;
        cur_pinned    <= pinned;
        cur_want      <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic pix_t any_pixel();
        return {8'($urandom), 8'($urandom), 8'($urandom)};
    endfunction

    // Per-channel flavor of an accumulate pass: full range, near zero,
    // empty, or bright. Lopsided sums drive gains to zero or to the clip.
    function automatic int channel_mode();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 0;
        else if (roll < 8)
            return 1;
        else if (roll == 8)
            return 3;
        else
            return 2;
    endfunction

    function automatic logic [gwwb_pkg::PIX_W-1:0] biased_value(input int mode);
        case (mode)
            1:       return gwwb_pkg::PIX_W'($urandom_range(0, 3));
            2:       return '0;
            3:       return gwwb_pkg::PIX_W'($urandom_range(200, 255));
            default: return gwwb_pkg::PIX_W'($urandom);
        endcase
    endfunction

    // Directed rows. Pinned results are the ones obvious by hand: unity gains
    // after reset, zero gains from empty sums, and equal sums giving exactly
    // 1.0. The rest go through the model.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        // gains still at reset: pixels pass unchanged
        '{gwwb_pkg::CMD_APPLY, 1'b0, {8'd255, 8'd0, 8'd128}, 21'd1, 1'b1,
          {8'd255, 8'd0, 8'd128}},
        '{gwwb_pkg::CMD_APPLY, 1'b0, {8'd1, 8'd254, 8'd127}, 21'd1, 1'b1,
          {8'd1, 8'd254, 8'd127}},
        // gain pass with no accumulate since reset: all gains zero
        '{gwwb_pkg::CMD_APPLY, 1'b1, {8'd255, 8'd255, 8'd255}, 21'd1, 1'b1, ZERO_PX},
        '{gwwb_pkg::CMD_APPLY, 1'b0, {8'd170, 8'd85, 8'd1}, 21'd1, 1'b1, ZERO_PX},
        // equal sums: unity gains
        '{gwwb_pkg::CMD_ACC, 1'b1, {8'd100, 8'd100, 8'd100}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_ACC, 1'b0, {8'd100, 8'd100, 8'd100}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_APPLY, 1'b1, {8'd17, 8'd200, 8'd255}, 21'd1, 1'b1,
          {8'd17, 8'd200, 8'd255}},
        '{gwwb_pkg::CMD_APPLY, 1'b0, {8'd0, 8'd128, 8'd1}, 21'd1, 1'b1,
          {8'd0, 8'd128, 8'd1}},
        // empty red channel
        '{gwwb_pkg::CMD_ACC, 1'b1, {8'd0, 8'd50, 8'd50}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_ACC, 1'b0, {8'd0, 8'd50, 8'd50}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_APPLY, 1'b1, {8'd255, 8'd255, 8'd255}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_APPLY, 1'b0, {8'd128, 8'd3, 8'd254}, 21'd1, 1'b0, ZERO_PX},
        // starved blue: gain clips at the top, outputs clamp at 255
        '{gwwb_pkg::CMD_ACC, 1'b1, {8'd255, 8'd255, 8'd1}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_ACC, 1'b0, {8'd255, 8'd255, 8'd0}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_APPLY, 1'b1, {8'd0, 8'd0, 8'd1}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_APPLY, 1'b0, {8'd255, 8'd255, 8'd255}, 21'd1, 1'b0, ZERO_PX},
        // accumulate with no first marker adds onto the old sums
        '{gwwb_pkg::CMD_ACC, 1'b0, {8'd10, 8'd20, 8'd30}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_APPLY, 1'b1, {8'd85, 8'd170, 8'd85}, 21'd1, 1'b0, ZERO_PX},
        // long pass sent back to back, then one more pixel onto it
        '{gwwb_pkg::CMD_ACC, 1'b1, {8'd255, 8'd255, 8'd0}, 21'd40, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_ACC, 1'b0, {8'd255, 8'd255, 8'd255}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_APPLY, 1'b1, {8'd255, 8'd255, 8'd255}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_APPLY, 1'b0, {8'd1, 8'd1, 8'd1}, 21'd1, 1'b0, ZERO_PX},
        // fresh pass: clears, equal sums again
        '{gwwb_pkg::CMD_ACC, 1'b1, {8'd255, 8'd255, 8'd255}, 21'd1, 1'b0, ZERO_PX},
        '{gwwb_pkg::CMD_APPLY, 1'b1, {8'd255, 8'd255, 8'd255}, 21'd1, 1'b1,
          {8'd255, 8'd255, 8'd255}},
        // second gain pass over the same sums
        '{gwwb_pkg::CMD_APPLY, 1'b1, {8'd0, 8'd0, 8'd0}, 21'd1, 1'b1, ZERO_PX}
    };

    initial
    begin
        int   random_items;
        int   frame_kind;
        int   n;
        int   mr;
        int   mg;
        int   mb;
        logic op;
        random_items = 0;

        wait (rst_n);
        @(posedge clk);

        // directed part; repeated rows go back to back with no gaps
        foreach (directed_rows[k])
        begin
            for (int i = 0; i < int'(directed_rows[k].reps); i++)
                send_pixel(directed_rows[k].op, directed_rows[k].first && (i == 0),
                           directed_rows[k].px, directed_rows[k].pinned,
                           directed_rows[k].want, i > 0);
        end

        // random part: mostly well-formed accumulate/apply frames
        random_phase = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            tx_calm    = ($urandom_range(0, 3) == 0);
            frame_kind = $urandom_range(0, 9);
            if (frame_kind == 0)
            begin
                // noise: any command, any marker
                n = $urandom_range(1, 4);
                repeat (n)
                    send_pixel(1'($urandom), 1'($urandom), any_pixel(), 1'b0, ZERO_PX,
                               1'b0);
                random_items += n;
            end
            else if (frame_kind == 1)
            begin
                // broken pass: no first marker at all
                op = 1'($urandom);
                n  = $urandom_range(1, 6);
                repeat (n)
                    send_pixel(op, 1'b0, any_pixel(), 1'b0, ZERO_PX, 1'b0);
                random_items += n;
            end
            else
            begin
                mr = channel_mode();
                mg = channel_mode();
                mb = channel_mode();
                n  = $urandom_range(1, 24);
                for (int i = 0; i < n; i++)
                    send_pixel(gwwb_pkg::CMD_ACC, i == 0,
                               {biased_value(mr), biased_value(mg), biased_value(mb)},
                               1'b0, ZERO_PX, 1'b0);
                random_items += n;
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++)
                    send_pixel(gwwb_pkg::CMD_APPLY, i == 0, any_pixel(), 1'b0, ZERO_PX,
                               1'b0);
                random_items += n;
            end
        end
        in_valid <= 1'b0;

        // drain, then linger past one gain division to catch stray outputs
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels, checked %0d balanced pixels over %0d gain passes.",
                 transfers_in, results_seen, gain_updates);
        $display("Gains clipped %0d times, zeroed %0d times; input backed up %0d cycles.",
                 gains_clipped, gains_zeroed, in_backed_up);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still pending.", expected_pixels.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
